### hw/rtl/rvc_pkg.sv
package rvc_pkg;

    // Packet layout
    localparam int PACKET_BYTES = 19;
    localparam int POS_W        = $clog2(PACKET_BYTES);

    localparam logic [POS_W-1:0] POS_HDR1      = POS_W'(0);
    localparam logic [POS_W-1:0] POS_HDR2      = POS_W'(1);
    localparam logic [POS_W-1:0] POS_SUM_FIRST = POS_W'(2);
    localparam logic [POS_W-1:0] POS_YAW_LO    = POS_W'(3);
    localparam logic [POS_W-1:0] POS_YAW_HI    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_LAST      = POS_W'(PACKET_BYTES - 1);

    // Moving average of yaw deltas; the tap count must be a power of two.
    localparam int AVG_TAPS  = 8;
    localparam int SLOT_W    = $clog2(AVG_TAPS);
    localparam int DELTA_W   = 17;
    localparam int TOTAL_W   = DELTA_W + SLOT_W;
    localparam int HZ_W      = 10;
    localparam int PROD_W    = TOTAL_W + HZ_W + 1;
    localparam int RATE_W    = 26;

    // Angles in centidegrees, held in 18-bit signed arithmetic.
    localparam logic signed [17:0] HALF_TURN = 18'sd18000;
    localparam logic signed [17:0] FULL_TURN = 18'sd36000;
    localparam int RATE_LIMIT = 18000000;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_BAD_SUM  = 2'd2,
        ST_OUTLIER  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RATE_HOLD   = 2'd0,
        RATE_UPDATE = 2'd1,
        RATE_CLEAR  = 2'd2
    } rate_op_t;

    typedef enum logic [1:0] {
        REG_HEADER   = 2'd0,
        REG_INVERT   = 2'd1,
        REG_MAX_STEP = 2'd2,
        REG_RATE_HZ  = 2'd3
    } reg_idx_t;

    // Event from the byte parser when the last byte of a packet arrives.
    typedef struct packed {
        logic        done;
        logic        sum_ok;
        logic [15:0] yaw_word;
    } pkt_t;

    // Tracker state snapshot handed to the output stage.
    typedef struct packed {
        logic                      have_yaw;
        logic signed [15:0]        cur_yaw;
        logic signed [15:0]        zero_off;
        logic signed [TOTAL_W-1:0] total;
        logic [31:0]               count;
        status_t                   status;
        rate_op_t                  rate_op;
    } stage_t;

endpackage

### hw/rtl/rvc_parser.sv
module rvc_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    header_byte,
    output rvc_pkg::pkt_t pkt
);
    import rvc_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       yaw_lo_reg, yaw_lo_next;
    logic [7:0]       yaw_hi_reg, yaw_hi_next;
    logic             hdr_match;

    assign hdr_match = (rx_byte == header_byte);

    always_comb
    begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        yaw_lo_next  = yaw_lo_reg;
        yaw_hi_next  = yaw_hi_reg;
        pkt.done     = 1'b0;
        pkt.sum_ok   = (rx_byte == sum_reg);
        pkt.yaw_word = {yaw_hi_reg, yaw_lo_reg};
        if (take)
        begin
            if (pos_reg == POS_HDR1)
            begin
                if (hdr_match)
                begin
                    pos_next = POS_HDR2;
                end
            end
            else if (pos_reg == POS_HDR2)
            begin
                // A mismatching second header byte is not retried as a first one.
                pos_next = hdr_match ? POS_SUM_FIRST : POS_HDR1;
            end
            else if (pos_reg >= POS_LAST)
            begin
                pkt.done = 1'b1;
                pos_next = POS_HDR1;
            end
            else
            begin
                sum_next = (pos_reg == POS_SUM_FIRST) ? rx_byte : sum_reg + rx_byte;
                if (pos_reg == POS_YAW_LO)
                begin
                    yaw_lo_next = rx_byte;
                end
                if (pos_reg == POS_YAW_HI)
                begin
                    yaw_hi_next = rx_byte;
                end
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            sum_reg    <= '0;
            yaw_lo_reg <= '0;
            yaw_hi_reg <= '0;
        end
        else
        begin
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            yaw_lo_reg <= yaw_lo_next;
            yaw_hi_reg <= yaw_hi_next;
        end
    end

endmodule

### hw/rtl/rvc_track.sv
module rvc_track (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            beat,
    input  logic            command,
    input  rvc_pkg::pkt_t   pkt,
    input  logic            yaw_sign_invert,
    input  logic [15:0]     max_step_centideg,
    output rvc_pkg::stage_t stage
);
    import rvc_pkg::*;

    logic signed [15:0]        cur_reg, cur_next;
    logic signed [15:0]        zero_reg, zero_next;
    logic                      have_reg, have_next;
    logic signed [DELTA_W-1:0] win_reg [AVG_TAPS];
    logic signed [DELTA_W-1:0] win_next [AVG_TAPS];
    logic signed [TOTAL_W-1:0] total_reg, total_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [31:0]               count_reg, count_next;
    stage_t                    stage_reg, stage_next;

    logic signed [17:0]        y_raw, y_sgn, y_wrap, d_raw, d_fold, d_mag;
    logic                      outlier;
    logic signed [TOTAL_W-1:0] total_sum;
    status_t                   status;
    rate_op_t                  rate_op;

    // Decode, optional negation, and wrap into one turn. The negated value
    // spans at most one extra half turn, so one correction is enough.
    always_comb
    begin
        y_raw = {{2{pkt.yaw_word[15]}}, pkt.yaw_word};
        y_sgn = yaw_sign_invert ? -y_raw : y_raw;
        if (y_sgn >= HALF_TURN)
        begin
            y_wrap = y_sgn - FULL_TURN;
        end
        else if (y_sgn < -HALF_TURN)
        begin
            y_wrap = y_sgn + FULL_TURN;
        end
        else
        begin
            y_wrap = y_sgn;
        end

        d_raw = y_wrap - {{2{cur_reg[15]}}, cur_reg};
        if (d_raw > HALF_TURN)
        begin
            d_fold = d_raw - FULL_TURN;
        end
        else if (d_raw < -HALF_TURN)
        begin
            d_fold = d_raw + FULL_TURN;
        end
        else
        begin
            d_fold = d_raw;
        end
        d_mag   = (d_fold < 0) ? -d_fold : d_fold;
        outlier = have_reg && (d_mag[15:0] > max_step_centideg);

        total_sum = total_reg
                    - {{SLOT_W{win_reg[slot_reg][DELTA_W-1]}}, win_reg[slot_reg]}
                    + {{SLOT_W{d_fold[DELTA_W-1]}}, d_fold[DELTA_W-1:0]};
    end

    always_comb
    begin
        cur_next   = cur_reg;
        zero_next  = zero_reg;
        have_next  = have_reg;
        win_next   = win_reg;
        total_next = total_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        status     = ST_NONE;
        rate_op    = RATE_HOLD;
        if (beat)
        begin
            if (command)
            begin
                // Zero heading is ignored until a yaw has been seen.
                if (have_reg)
                begin
                    zero_next  = cur_reg;
                    total_next = '0;
                    slot_next  = '0;
                    rate_op    = RATE_CLEAR;
                    for (int i = 0; i < AVG_TAPS; i++)
                    begin
                        win_next[i] = '0;
                    end
                end
            end
            else if (pkt.done)
            begin
                if (!pkt.sum_ok)
                begin
                    status = ST_BAD_SUM;
                end
                else if (outlier)
                begin
                    status = ST_OUTLIER;
                end
                else
                begin
                    status = ST_ACCEPTED;
                    // The first packet only seeds the yaw and adds no delta.
                    if (have_reg)
                    begin
                        win_next[slot_reg] = d_fold[DELTA_W-1:0];
                        total_next         = total_sum;
                        slot_next          = (slot_reg == SLOT_W'(AVG_TAPS - 1)) ?
                                             '0 : slot_reg + SLOT_W'(1);
                        rate_op            = RATE_UPDATE;
                    end
                    cur_next   = y_wrap[15:0];
                    have_next  = 1'b1;
                    count_next = count_reg + 32'd1;
                end
            end
        end

        stage_next.have_yaw = have_next;
        stage_next.cur_yaw  = cur_next;
        stage_next.zero_off = zero_next;
        stage_next.total    = total_next;
        stage_next.count    = count_next;
        stage_next.status   = status;
        stage_next.rate_op  = rate_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            zero_reg  <= '0;
            have_reg  <= 1'b0;
            total_reg <= '0;
            slot_reg  <= '0;
            count_reg <= '0;
            for (int i = 0; i < AVG_TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            cur_reg   <= cur_next;
            zero_reg  <= zero_next;
            have_reg  <= have_next;
            total_reg <= total_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
            win_reg   <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

### hw/rtl/rvc_calc.sv
module rvc_calc (
    input  rvc_pkg::stage_t                   stage,
    input  logic [rvc_pkg::HZ_W-1:0]          packet_rate_hz,
    output logic signed [15:0]                heading,
    output logic signed [rvc_pkg::RATE_W-1:0] rate
);
    import rvc_pkg::*;

    localparam int AVG_SHIFT = $clog2(AVG_TAPS);
    localparam logic signed [PROD_W-1:0] LIMIT_P = PROD_W'(RATE_LIMIT);
    localparam logic signed [RATE_W-1:0] LIMIT_R = RATE_W'(RATE_LIMIT);
    localparam logic signed [PROD_W-1:0] ROUND_P = PROD_W'(AVG_TAPS - 1);

    logic signed [17:0]       diff, wrapped;
    logic signed [PROD_W-1:0] tot_x, hz_x, prod, biased, quo;

    always_comb
    begin
        diff = {{2{stage.cur_yaw[15]}}, stage.cur_yaw}
               - {{2{stage.zero_off[15]}}, stage.zero_off};
        if (diff >= HALF_TURN)
        begin
            wrapped = diff - FULL_TURN;
        end
        else if (diff < -HALF_TURN)
        begin
            wrapped = diff + FULL_TURN;
        end
        else
        begin
            wrapped = diff;
        end
        heading = stage.have_yaw ? wrapped[15:0] : '0;
    end

    // Average times cadence; the divide by the tap count truncates toward zero.
    always_comb
    begin
        tot_x  = {{(PROD_W - TOTAL_W){stage.total[TOTAL_W-1]}}, stage.total};
        hz_x   = {{(PROD_W - HZ_W){1'b0}}, packet_rate_hz};
        prod   = tot_x * hz_x;
        biased = (prod < 0) ? prod + ROUND_P : prod;
        quo    = biased >>> AVG_SHIFT;
        if (quo > LIMIT_P)
        begin
            rate = LIMIT_R;
        end
        else if (quo < -LIMIT_P)
        begin
            rate = -LIMIT_R;
        end
        else
        begin
            rate = quo[RATE_W-1:0];
        end
    end

endmodule

### hw/rtl/rvc_yaw_packet_tracker.sv
// Channel   Dir  Beat contents
// --------  ---  ---------------------------------------------------------------
// s_*       in   tuser: command; tdata[7:0]: rx_byte
// m_*       out  tuser: packet_status; tdata: heading, rate, packet_count, yaw_valid
// APB       in   header_byte @0x0, yaw_sign_invert @0x4, max_step @0x8, rate_hz @0xC
//
// Every input beat yields exactly one output beat, passing first through the
// tracker stage. One beat can be taken each cycle while the output accepts: the
// tracker stage updates all packet and window state at the accept edge, and the
// output stage forms heading and rate (one 20x10 multiply) into the output register.
// Reset is asynchronous and active low and clears parser, tracker and rate
// state; configuration registers return to their defaults.
// A stalled output holds; a new beat is still taken while the tracker stage is free.
module rvc_yaw_packet_tracker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    input  logic        s_tuser,    // [0] command (1 = zero heading)

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,    // [15:0] heading_centideg, [41:16] rate_centideg_per_s,
                                    // [73:42] packet_count, [74] yaw_valid, [79:75] zero
    output logic [1:0]  m_tuser,    // [1:0] packet_status

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rvc_pkg::*;

    // Configuration registers
    logic [7:0]      header_reg;
    logic            invert_reg;
    logic [15:0]     max_step_reg;
    logic [HZ_W-1:0] rate_hz_reg;
    logic            cfg_write;
    reg_idx_t        cfg_idx;

    // Pipeline control
    logic            beat;
    logic            s1_valid_reg, s1_valid_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_load;

    pkt_t            pkt;
    stage_t          stage;
    logic signed [15:0]       heading;
    logic signed [RATE_W-1:0] rate_calc;

    // Output register
    logic signed [15:0]       heading_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic [31:0]              count_reg;
    logic                     yaw_valid_reg;
    status_t                  status_reg;

    // -------------------------------------------------------------------------
    // APB register file. The port never waits.
    // -------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= 8'd170;
            invert_reg   <= 1'b0;
            max_step_reg <= 16'd3000;
            rate_hz_reg  <= HZ_W'(100);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_HEADER:   header_reg   <= pwdata[7:0];
                REG_INVERT:   invert_reg   <= pwdata[0];
                REG_MAX_STEP: max_step_reg <= pwdata[15:0];
                REG_RATE_HZ:  rate_hz_reg  <= pwdata[HZ_W-1:0];
                default:      header_reg   <= header_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_HEADER:   prdata = {24'd0, header_reg};
            REG_INVERT:   prdata = {31'd0, invert_reg};
            REG_MAX_STEP: prdata = {16'd0, max_step_reg};
            REG_RATE_HZ:  prdata = {{(32 - HZ_W){1'b0}}, rate_hz_reg};
            default:      prdata = '0;
        endcase
    end

    // -------------------------------------------------------------------------
    // Handshake. The tracker stage takes a beat whenever it is empty or its
    // content moves on to the output register in the same cycle.
    // -------------------------------------------------------------------------
    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_load;
    assign beat     = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (beat)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // -------------------------------------------------------------------------
    // Datapath
    // -------------------------------------------------------------------------
    rvc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (beat && !s_tuser),
        .rx_byte     (s_tdata),
        .header_byte (header_reg),
        .pkt         (pkt)
    );

    rvc_track u_track (
        .clk               (clk),
        .rst_n             (rst_n),
        .beat              (beat),
        .command           (s_tuser),
        .pkt               (pkt),
        .yaw_sign_invert   (invert_reg),
        .max_step_centideg (max_step_reg),
        .stage             (stage)
    );

    rvc_calc u_calc (
        .stage          (stage),
        .packet_rate_hz (rate_hz_reg),
        .heading        (heading),
        .rate           (rate_calc)
    );

    // The rate register is part of the tracker state: it keeps its value
    // until an accepted delta recomputes it or a zero heading clears it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= '0;
        end
        else if (out_load)
        begin
            case (stage.rate_op)
                RATE_UPDATE: rate_reg <= rate_calc;
                RATE_CLEAR:  rate_reg <= '0;
                default:     rate_reg <= rate_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            heading_reg   <= heading;
            count_reg     <= stage.count;
            yaw_valid_reg <= stage.have_yaw;
            status_reg    <= stage.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, yaw_valid_reg, count_reg, rate_reg, heading_reg};
    assign m_tuser  = status_reg;

endmodule
